// ===== src/kds_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed descriptor store package
// Shared types, widths and codes for the keyed descriptor store.
// ----------------------------------------------------------------------------
package kds_pkg;

    localparam int KEY_W      = 256;
    localparam int BYTE_W     = 8;
    localparam int REQ_LEN_W  = 10;
    localparam int FLEN_W     = 7;
    localparam int COUNT_OUT_W = 5;

    localparam int DEF_ENTRIES   = 16;
    localparam int DEF_MAX_BYTES = 64;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_BAD       = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

    // State of the persist sequence in progress.
    typedef enum logic [1:0] {
        PS_IDLE = 2'd0,
        PS_OK   = 2'd1,
        PS_BAD  = 2'd2,
        PS_FULL = 2'd3
    } pstat_t;

    // Back end sequencer states.
    typedef enum logic [3:0] {
        BS_IDLE,
        BS_CMP,
        BS_SEL,
        BS_LEN,
        BS_ONE,
        BS_RD,
        BS_RDW,
        BS_EXEC,
        BS_DONE
    } back_state_t;

    // Classified command word passed from front to back.
    typedef struct packed {
        logic                 is_resolve;
        logic                 first;
        logic                 bad;
        logic [KEY_W-1:0]     key;
        logic [BYTE_W-1:0]    data;
        logic                 last;
        logic [REQ_LEN_W-1:0] cap;
        logic                 want;
    } cmd_t;

endpackage

// ===== src/kds_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed descriptor store front end
// Accepts input words, tracks persist framing and checks first words.
// ----------------------------------------------------------------------------
module kds_front #(
    parameter int MAX_BYTES = kds_pkg::DEF_MAX_BYTES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          req_type,
    input  logic [63:0]                   key_w0,
    input  logic [63:0]                   key_w1,
    input  logic [63:0]                   key_w2,
    input  logic [63:0]                   key_w3,
    input  logic [kds_pkg::REQ_LEN_W-1:0] pay_length,
    input  logic [7:0]                    in_byte,
    input  logic                          in_last,
    input  logic [kds_pkg::REQ_LEN_W-1:0] read_capacity,
    input  logic                          want_bytes,
    input  logic                          q_full,
    output logic                          q_push,
    output kds_pkg::cmd_t                 q_cmd
);
    import kds_pkg::*;

    logic open_reg;
    logic open_next;
    logic [KEY_W-1:0] key_all;

    assign key_all  = {key_w3, key_w2, key_w1, key_w0};
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    // Classify the word: a persist word is first when no sequence is open.
    always_comb
    begin
        q_cmd.is_resolve = req_type;
        q_cmd.first      = !req_type && !open_reg;
        q_cmd.bad        = (pay_length == '0) ||
                           (pay_length > REQ_LEN_W'(MAX_BYTES)) ||
                           (key_all == '0);
        q_cmd.key        = key_all;
        q_cmd.data       = in_byte;
        q_cmd.last       = in_last;
        q_cmd.cap        = read_capacity;
        q_cmd.want       = want_bytes;
    end

    // A persist sequence stays open until its last word.
    always_comb
    begin
        open_next = open_reg;
        if (q_push && !req_type)
        begin
            open_next = !in_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
        end
        else
        begin
            open_reg <= open_next;
        end
    end

endmodule

// ===== src/kds_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed descriptor store command queue
// Two-entry register queue between the front and back ends.
// ----------------------------------------------------------------------------
module kds_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  kds_pkg::cmd_t push_cmd,
    input  logic          pop,
    output kds_pkg::cmd_t head_cmd,
    output logic          full,
    output logic          empty
);
    import kds_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign head_cmd = slot_reg[rd_ptr_reg];

    // Storage for queued commands.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

// ===== src/kds_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed descriptor store back end
// Key lookup, entry table, payload memory and result output register.
// ----------------------------------------------------------------------------
module kds_back #(
    parameter int ENTRIES   = kds_pkg::DEF_ENTRIES,
    parameter int MAX_BYTES = kds_pkg::DEF_MAX_BYTES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_empty,
    input  kds_pkg::cmd_t                   q_cmd,
    output logic                            q_pop,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      status,
    output logic [kds_pkg::FLEN_W-1:0]      found_length,
    output logic [7:0]                      out_byte,
    output logic                            byte_valid,
    output logic                            out_last,
    output logic [kds_pkg::COUNT_OUT_W-1:0] entry_count
);
    import kds_pkg::*;

    localparam int SW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW    = $clog2(ENTRIES + 1);
    localparam int DEPTH = ENTRIES * MAX_BYTES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    back_state_t state_reg, state_next;
    cmd_t        cur_reg, cur_next;
    pstat_t      pstat_reg, pstat_next;
    logic [SW-1:0]     slot_reg, slot_next;
    logic [SW-1:0]     rslot_reg, rslot_next;
    logic [KEY_W-1:0]  pkey_reg, pkey_next;
    logic [FLEN_W-1:0] wp_reg, wp_next;
    logic [FLEN_W-1:0] flen_reg, flen_next;
    logic [FLEN_W-1:0] n_reg, n_next;
    logic [FLEN_W-1:0] idx_reg, idx_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [ENTRIES-1:0] hit_vec_reg, hit_vec;

    logic [KEY_W-1:0]  key_reg [ENTRIES];
    logic [FLEN_W-1:0] len_mem [ENTRIES];
    logic [7:0]        pay_mem [DEPTH];
    logic [FLEN_W-1:0] len_rd_reg;
    logic [7:0]        rd_byte_reg;

    logic              commit_we;
    logic              pay_we;
    logic [AW-1:0]     pay_waddr;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;

    logic              hit_any;
    logic [SW-1:0]     hit_idx;
    logic              free_any;
    logic [SW-1:0]     free_idx;
    logic [FLEN_W-1:0] n_calc;
    logic [REQ_LEN_W-1:0] flen_wide;

    logic              ob_free;
    logic              ld;
    logic              out_valid_reg;
    status_t           o_status, status_reg;
    logic [FLEN_W-1:0] o_len, len_out_reg;
    logic [7:0]        o_byte, byte_out_reg;
    logic              o_bv, bv_reg;
    logic              o_last, last_reg;
    logic [CW-1:0]     o_count, count_out_reg;
    logic [8:0]        count_ext;

    // Parallel key compare against every valid entry.
    always_comb
    begin
        for (int e = 0; e < ENTRIES; e++)
        begin
            hit_vec[e] = valid_reg[e] && (key_reg[e] == cur_reg.key);
        end
    end

    // Lowest matching entry and lowest free entry.
    always_comb
    begin
        hit_any  = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int e = ENTRIES - 1; e >= 0; e--)
        begin
            if (hit_vec_reg[e])
            begin
                hit_any = 1'b1;
                hit_idx = SW'(e);
            end
            if (!valid_reg[e])
            begin
                free_any = 1'b1;
                free_idx = SW'(e);
            end
        end
    end

    // Bytes a resolve returns: none unless wanted, else the stored length capped by the capacity.
    assign flen_wide = REQ_LEN_W'(len_rd_reg);
    always_comb
    begin
        if (!cur_reg.want)
        begin
            n_calc = '0;
        end
        else if (flen_wide < cur_reg.cap)
        begin
            n_calc = len_rd_reg;
        end
        else
        begin
            n_calc = FLEN_W'(cur_reg.cap);
        end
    end

    assign ob_free = !out_valid_reg || !out_stall;

    // Sequencer: next state, datapath updates and result loads.
    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        pstat_next = pstat_reg;
        slot_next  = slot_reg;
        rslot_next = rslot_reg;
        pkey_next  = pkey_reg;
        wp_next    = wp_reg;
        flen_next  = flen_reg;
        n_next     = n_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        valid_next = valid_reg;
        q_pop      = 1'b0;
        commit_we  = 1'b0;
        pay_we     = 1'b0;
        pay_waddr  = AW'(slot_reg) * AW'(MAX_BYTES) + AW'(wp_reg);
        rd_en      = 1'b0;
        rd_addr    = AW'(rslot_reg) * AW'(MAX_BYTES) + AW'(idx_reg);
        ld         = 1'b0;
        o_status   = STAT_OK;
        o_len      = '0;
        o_byte     = '0;
        o_bv       = 1'b0;
        o_last     = 1'b1;
        o_count    = count_reg;
        unique case (state_reg)
            BS_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_cmd;
                    if (!q_cmd.is_resolve && !q_cmd.first)
                    begin
                        state_next = BS_EXEC;
                    end
                    else
                    begin
                        state_next = BS_CMP;
                    end
                end
            end
            BS_CMP:
            begin
                state_next = BS_SEL;
            end
            BS_SEL:
            begin
                if (!cur_reg.is_resolve)
                begin
                    wp_next    = '0;
                    state_next = BS_EXEC;
                    if (cur_reg.bad)
                    begin
                        pstat_next = PS_BAD;
                    end
                    else if (hit_any)
                    begin
                        pstat_next = PS_OK;
                        slot_next  = hit_idx;
                        pkey_next  = cur_reg.key;
                    end
                    else if (free_any)
                    begin
                        pstat_next = PS_OK;
                        slot_next  = free_idx;
                        pkey_next  = cur_reg.key;
                    end
                    else
                    begin
                        pstat_next = PS_FULL;
                    end
                end
                else if (hit_any)
                begin
                    // A resolve keeps its own entry so an open persist is untouched.
                    rslot_next = hit_idx;
                    state_next = BS_LEN;
                end
                else if (ob_free)
                begin
                    ld         = 1'b1;
                    o_status   = STAT_NOT_FOUND;
                    state_next = BS_IDLE;
                end
            end
            BS_LEN:
            begin
                flen_next = len_rd_reg;
                n_next    = n_calc;
                idx_next  = '0;
                if (n_calc == '0)
                begin
                    state_next = BS_ONE;
                end
                else
                begin
                    state_next = BS_RD;
                end
            end
            BS_ONE:
            begin
                if (ob_free)
                begin
                    ld         = 1'b1;
                    o_len      = flen_reg;
                    state_next = BS_IDLE;
                end
            end
            BS_RD:
            begin
                rd_en      = 1'b1;
                state_next = BS_RDW;
            end
            BS_RDW:
            begin
                if (ob_free)
                begin
                    ld       = 1'b1;
                    o_len    = flen_reg;
                    o_byte   = rd_byte_reg;
                    o_bv     = 1'b1;
                    o_last   = (idx_reg + FLEN_W'(1) == n_reg);
                    idx_next = idx_reg + FLEN_W'(1);
                    if (o_last)
                    begin
                        state_next = BS_IDLE;
                    end
                    else
                    begin
                        state_next = BS_RD;
                    end
                end
            end
            BS_EXEC:
            begin
                if (pstat_reg == PS_OK && wp_reg < FLEN_W'(MAX_BYTES))
                begin
                    pay_we  = 1'b1;
                    wp_next = wp_reg + FLEN_W'(1);
                end
                if (cur_reg.last)
                begin
                    state_next = BS_DONE;
                end
                else
                begin
                    state_next = BS_IDLE;
                end
            end
            BS_DONE:
            begin
                if (ob_free)
                begin
                    ld         = 1'b1;
                    pstat_next = PS_IDLE;
                    wp_next    = '0;
                    state_next = BS_IDLE;
                    if (pstat_reg == PS_OK)
                    begin
                        commit_we = 1'b1;
                        o_len     = wp_reg;
                        if (!valid_reg[slot_reg])
                        begin
                            valid_next[slot_reg] = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                        o_count = count_next;
                    end
                    else if (pstat_reg == PS_FULL)
                    begin
                        o_status = STAT_FULL;
                    end
                    else
                    begin
                        o_status = STAT_BAD;
                    end
                end
            end
            default:
            begin
                state_next = BS_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BS_IDLE;
            pstat_reg     <= PS_IDLE;
            slot_reg      <= '0;
            rslot_reg     <= '0;
            wp_reg        <= '0;
            idx_reg       <= '0;
            count_reg     <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pstat_reg <= pstat_next;
            slot_reg  <= slot_next;
            rslot_reg <= rslot_next;
            wp_reg    <= wp_next;
            idx_reg   <= idx_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
            if (ld)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers and the result word.
    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        pkey_reg    <= pkey_next;
        flen_reg    <= flen_next;
        n_reg       <= n_next;
        hit_vec_reg <= hit_vec;
        if (ld)
        begin
            status_reg    <= o_status;
            len_out_reg   <= o_len;
            byte_out_reg  <= o_byte;
            bv_reg        <= o_bv;
            last_reg      <= o_last;
            count_out_reg <= o_count;
        end
    end

    // Entry keys and lengths, written on commit.
    always_ff @(posedge clk)
    begin
        if (commit_we)
        begin
            key_reg[slot_reg] <= pkey_reg;
            len_mem[slot_reg] <= wp_reg;
        end
        len_rd_reg <= len_mem[hit_idx];
    end

    // Payload memory with registered read.
    always_ff @(posedge clk)
    begin
        if (pay_we)
        begin
            pay_mem[pay_waddr] <= cur_reg.data;
        end
        if (rd_en)
        begin
            rd_byte_reg <= pay_mem[rd_addr];
        end
    end

    assign count_ext    = 9'(count_out_reg);
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign found_length = len_out_reg;
    assign out_byte     = byte_out_reg;
    assign byte_valid   = bv_reg;
    assign out_last     = last_reg;
    assign entry_count  = count_ext[COUNT_OUT_W-1:0];

endmodule

// ===== src/keyed_descriptor_store_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed descriptor store
// Key/value table with persist streaming and resolve lookup.
// ----------------------------------------------------------------------------
//  Channel | Handshake            | Word
//  in      | in_valid / in_stall  | request word: persist byte or resolve
//  out     | out_valid / out_stall| result word: status, length, byte
//
// A persist byte after the first goes straight to the write step in the back
// end; a first byte adds key compare and entry select, a last byte a report.
// A resolve does key compare and entry select, then reports not found or reads
// the length; each returned byte needs a registered payload read first.
// Reset clears the valid marks, entry count and all control state at once.
// A two-word queue lets the input accept words while the output stalls, until full.
// ----------------------------------------------------------------------------
module keyed_descriptor_store_core #(
    parameter int ENTRIES   = kds_pkg::DEF_ENTRIES,
    parameter int MAX_BYTES = kds_pkg::DEF_MAX_BYTES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            req_type,
    input  logic [63:0]                     key_w0,
    input  logic [63:0]                     key_w1,
    input  logic [63:0]                     key_w2,
    input  logic [63:0]                     key_w3,
    input  logic [kds_pkg::REQ_LEN_W-1:0]   pay_length,
    input  logic [7:0]                      in_byte,
    input  logic                            in_last,
    input  logic [kds_pkg::REQ_LEN_W-1:0]   read_capacity,
    input  logic                            want_bytes,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      status,
    output logic [kds_pkg::FLEN_W-1:0]      found_length,
    output logic [7:0]                      out_byte,
    output logic                            byte_valid,
    output logic                            out_last,
    output logic [kds_pkg::COUNT_OUT_W-1:0] entry_count
);
    import kds_pkg::*;

    cmd_t push_cmd;
    cmd_t head_cmd;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;

    kds_front #(
        .MAX_BYTES (MAX_BYTES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .key_w0        (key_w0),
        .key_w1        (key_w1),
        .key_w2        (key_w2),
        .key_w3        (key_w3),
        .pay_length    (pay_length),
        .in_byte       (in_byte),
        .in_last       (in_last),
        .read_capacity (read_capacity),
        .want_bytes    (want_bytes),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (push_cmd)
    );

    kds_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    kds_back #(
        .ENTRIES   (ENTRIES),
        .MAX_BYTES (MAX_BYTES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_cmd        (head_cmd),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .found_length (found_length),
        .out_byte     (out_byte),
        .byte_valid   (byte_valid),
        .out_last     (out_last),
        .entry_count  (entry_count)
    );

endmodule

// ===== tb/kds_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed descriptor store checker
// Watches both channels of the store. Every accepted request word runs
// through a local model of the table, and the result words that it predicts
// are queued. Each accepted result word is then compared field by field with
// the oldest queued prediction.
// ----------------------------------------------------------------------------
module kds_checker #(
    parameter int ENTRIES   = 16,
    parameter int MAX_BYTES = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic                            req_type,
    input  logic [63:0]                     key_w0,
    input  logic [63:0]                     key_w1,
    input  logic [63:0]                     key_w2,
    input  logic [63:0]                     key_w3,
    input  logic [kds_pkg::REQ_LEN_W-1:0]   pay_length,
    input  logic [7:0]                      in_byte,
    input  logic                            in_last,
    input  logic [kds_pkg::REQ_LEN_W-1:0]   read_capacity,
    input  logic                            want_bytes,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [1:0]                      status,
    input  logic [kds_pkg::FLEN_W-1:0]      found_length,
    input  logic [7:0]                      out_byte,
    input  logic                            byte_valid,
    input  logic                            out_last,
    input  logic [kds_pkg::COUNT_OUT_W-1:0] entry_count,
    output int                              fail_count,
    output int                              results_owed
);
    import kds_pkg::*;

    typedef struct packed {
        status_t                st;
        logic [FLEN_W-1:0]      flen;
        logic [7:0]             data;
        logic                   bv;
        logic                   last;
        logic [COUNT_OUT_W-1:0] cnt;
    } result_t;

    result_t           owed_q[$];

    // Local copy of the table.
    logic              slot_used[ENTRIES];
    logic [KEY_W-1:0]  slot_key[ENTRIES];
    logic [6:0]        slot_len[ENTRIES];
    logic [7:0]        slot_data[ENTRIES][MAX_BYTES];
    int                used;
    int                open_slot;
    pstat_t            open_stat;
    int                fill;
    logic [KEY_W-1:0]  open_key;

    function automatic result_t make_result(status_t st, int flen, logic [7:0] data,
                                            logic bv, logic last);
        result_t r;
        r.st   = st;
        r.flen = flen[FLEN_W-1:0];
        r.data = data;
        r.bv   = bv;
        r.last = last;
        r.cnt  = used[COUNT_OUT_W-1:0];
        return r;
    endfunction

    // Apply one request word to the table and queue the results it causes.
    task automatic store_request(logic is_resolve, logic [KEY_W-1:0] k, int plen,
                                 logic [7:0] data, logic fin, int cap, logic want);
        int  pick;
        int  n;
        bit  have;
        bit  hit;
        begin
            if (!is_resolve) begin
                // The first word of a sequence checks it and picks the entry.
                if (open_stat == PS_IDLE) begin
                    fill = 0;
                    if (plen == 0 || plen > MAX_BYTES || k == '0) begin
                        open_stat = PS_BAD;
                    end
                    else begin
                        have = 0;
                        hit  = 0;
                        pick = 0;
                        for (int e = 0; e < ENTRIES && !hit; e++) begin
                            if (slot_used[e] && slot_key[e] == k) begin
                                pick = e;
                                have = 1;
                                hit  = 1;
                            end
                            else if (!slot_used[e] && !have) begin
                                pick = e;
                                have = 1;
                            end
                        end
                        if (have) begin
                            open_stat = PS_OK;
                            open_slot = pick;
                            open_key  = k;
                        end
                        else begin
                            open_stat = PS_FULL;
                        end
                    end
                end
                if (open_stat == PS_OK && fill < MAX_BYTES) begin
                    slot_data[open_slot][fill] = data;
                    fill++;
                end
                if (fin) begin
                    if (open_stat == PS_OK) begin
                        if (!slot_used[open_slot]) begin
                            slot_used[open_slot] = 1;
                            used++;
                        end
                        slot_key[open_slot] = open_key;
                        slot_len[open_slot] = fill[6:0];
                        owed_q.push_back(make_result(STAT_OK, fill, 8'h00, 0, 1));
                    end
                    else begin
                        owed_q.push_back(make_result(open_stat == PS_FULL ? STAT_FULL
                                                     : STAT_BAD, 0, 8'h00, 0, 1));
                    end
                    open_stat = PS_IDLE;
                    fill      = 0;
                end
            end
            else begin
                // Lookup: the first matching entry answers.
                hit = 0;
                for (int e = 0; e < ENTRIES && !hit; e++) begin
                    if (slot_used[e] && slot_key[e] == k) begin
                        hit = 1;
                        n = want ? ((slot_len[e] < cap) ? int'(slot_len[e]) : cap) : 0;
                        if (n > MAX_BYTES)
                            n = MAX_BYTES;
                        if (n == 0)
                            owed_q.push_back(make_result(STAT_OK, slot_len[e], 8'h00, 0, 1));
                        for (int i = 0; i < n; i++)
                            owed_q.push_back(make_result(STAT_OK, slot_len[e],
                                                         slot_data[e][i], 1, i + 1 == n));
                    end
                end
                if (!hit)
                    owed_q.push_back(make_result(STAT_NOT_FOUND, 0, 8'h00, 0, 1));
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want_r;
        result_t got_r;
        if (!rst_n) begin
            for (int e = 0; e < ENTRIES; e++)
                slot_used[e] = 0;
            used         = 0;
            open_slot    = 0;
            open_stat    = PS_IDLE;
            fill         = 0;
            open_key     = '0;
            fail_count   = 0;
            results_owed = 0;
            owed_q.delete();
        end
        else begin
            // Results first: a result never belongs to a word accepted at the same edge.
            if (out_valid && !out_stall) begin
                got_r.st   = status_t'(status);
                got_r.flen = found_length;
                got_r.data = out_byte;
                got_r.bv   = byte_valid;
                got_r.last = out_last;
                got_r.cnt  = entry_count;
                if (owed_q.size() == 0) begin
                    $display("%0t: result word expected none actual %h", $time, got_r);
                    fail_count++;
                end
                else begin
                    want_r = owed_q.pop_front();
                    if (got_r.st !== want_r.st)
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want_r.st, got_r.st);
                    if (got_r.flen !== want_r.flen)
                        $display("%0t: found_length expected %0d actual %0d",
                                 $time, want_r.flen, got_r.flen);
                    if (got_r.data !== want_r.data)
                        $display("%0t: out_byte expected %h actual %h",
                                 $time, want_r.data, got_r.data);
                    if (got_r.bv !== want_r.bv)
                        $display("%0t: byte_valid expected %b actual %b",
                                 $time, want_r.bv, got_r.bv);
                    if (got_r.last !== want_r.last)
                        $display("%0t: out_last expected %b actual %b",
                                 $time, want_r.last, got_r.last);
                    if (got_r.cnt !== want_r.cnt)
                        $display("%0t: entry_count expected %0d actual %0d",
                                 $time, want_r.cnt, got_r.cnt);
                    if (got_r !== want_r)
                        fail_count++;
                end
            end
            if (in_valid && !in_stall)
                store_request(req_type, {key_w3, key_w2, key_w1, key_w0}, pay_length,
                              in_byte, in_last, read_capacity, want_bytes);
            results_owed = owed_q.size();
        end
    end

endmodule

// ===== tb/tb_keyed_descriptor_store_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed descriptor store testbench
// Drives directed and random persist and resolve words into the store with
// random idle cycles on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_keyed_descriptor_store_core;
    import kds_pkg::*;

    localparam int NKEYS = 20;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic                   req_type;
    logic [63:0]            key_w0;
    logic [63:0]            key_w1;
    logic [63:0]            key_w2;
    logic [63:0]            key_w3;
    logic [REQ_LEN_W-1:0]   pay_length;
    logic [7:0]             in_byte;
    logic                   in_last;
    logic [REQ_LEN_W-1:0]   read_capacity;
    logic                   want_bytes;
    logic                   out_valid;
    logic                   out_stall;
    logic [1:0]             status;
    logic [FLEN_W-1:0]      found_length;
    logic [7:0]             out_byte;
    logic                   byte_valid;
    logic                   out_last;
    logic [COUNT_OUT_W-1:0] entry_count;
    int                     fail_count;
    int                     results_owed;

    logic [KEY_W-1:0]       key_pool[NKEYS];
    bit                     gaps_on;
    int                     words_sent;

    keyed_descriptor_store_core DUT (.*);

    kds_checker u_checker (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Receiver stalls at random while gaps are enabled.
    always @(negedge clk)
        out_stall <= gaps_on && ($urandom_range(99) < 24);

    initial
    begin
        #2000000;
        $display("tb_keyed_descriptor_store_core: FAIL");
        $finish;
    end

    // Present one request word and hold it until accepted.
    task automatic send_word(logic is_resolve, logic [KEY_W-1:0] k, int plen,
                             logic [7:0] data, logic fin, int cap, logic want);
        while (gaps_on && $urandom_range(99) < 24) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        req_type      <= is_resolve;
        {key_w3, key_w2, key_w1, key_w0} <= k;
        pay_length    <= plen[REQ_LEN_W-1:0];
        in_byte       <= data;
        in_last       <= fin;
        read_capacity <= cap[REQ_LEN_W-1:0];
        want_bytes    <= want;
        in_valid      <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
        @(negedge clk);
    endtask

    // A whole persist sequence of n bytes, all under one key.
    task automatic persist_seq(logic [KEY_W-1:0] k, int plen, int n);
        for (int i = 0; i < n; i++)
            send_word(1'b0, k, plen, $urandom, i == n - 1, $urandom, $urandom);
    endtask

    initial
    begin
        int n;
        int pick;
        int persists;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        out_stall     = 1'b0;
        req_type      = 1'b0;
        {key_w3, key_w2, key_w1, key_w0} = '0;
        pay_length    = '0;
        in_byte       = '0;
        in_last       = 1'b0;
        read_capacity = '0;
        want_bytes    = 1'b0;
        gaps_on       = 1'b1;
        words_sent    = 0;
        persists      = 0;
        for (int i = 0; i < NKEYS; i++)
            key_pool[i] = {$urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom | 32'h1};
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: extreme bytes, a one-byte entry and one declared at maximum length.
        send_word(1'b0, key_pool[0], 1, 8'hFF, 1'b1, 0, 1'b0);
        send_word(1'b0, key_pool[1], DEF_MAX_BYTES, 8'h00, 1'b0, 0, 1'b0);
        // A key change mid-sequence is ignored; the first key is committed.
        send_word(1'b0, key_pool[2], 1023, 8'hA5, 1'b0, 0, 1'b0);
        send_word(1'b0, '1, 0, 8'h5A, 1'b1, 0, 1'b0);
        // Resolve with all bytes, no bytes wanted, zero capacity, and a short capacity.
        send_word(1'b1, key_pool[1], 0, 8'h00, 1'b0, 1023, 1'b1);
        send_word(1'b1, key_pool[1], 0, 8'h00, 1'b0, 1023, 1'b0);
        send_word(1'b1, key_pool[1], 0, 8'h00, 1'b0, 0, 1'b1);
        send_word(1'b1, key_pool[1], 0, 8'h00, 1'b0, 2, 1'b1);
        // Bad requests: zero length, length over the limit, all-zero key.
        send_word(1'b0, key_pool[3], 0, 8'h11, 1'b1, 0, 1'b0);
        persist_seq(key_pool[3], 65, 2);
        send_word(1'b0, key_pool[3], 1023, 8'h22, 1'b1, 0, 1'b0);
        persist_seq('0, 5, 2);
        // Lookups that miss: the all-zero key and a key never stored.
        send_word(1'b1, '0, 0, 8'h00, 1'b0, 1023, 1'b1);
        send_word(1'b1, key_pool[NKEYS-1], 0, 8'h00, 1'b0, 1023, 1'b1);
        // Rewrite an existing entry, with a lookup while the rewrite is open.
        send_word(1'b0, key_pool[0], 2, 8'h33, 1'b0, 0, 1'b0);
        send_word(1'b1, key_pool[0], 0, 8'h00, 1'b0, 1023, 1'b1);
        send_word(1'b0, key_pool[0], 2, 8'h44, 1'b1, 0, 1'b0);
        send_word(1'b1, key_pool[0], 0, 8'h00, 1'b0, 1023, 1'b1);

        // Random: mostly well-formed sequences; the first ones fill the table.
        while (words_sent < 125) begin
            gaps_on = !(words_sent >= 60 && words_sent < 95);
            pick = $urandom_range(99);
            if (pick < 70) begin
                n = ($urandom_range(9) == 0) ? $urandom_range(1, 68) : $urandom_range(1, 6);
                persist_seq(key_pool[(persists < NKEYS - 2) ? persists + 2
                                     : $urandom_range(NKEYS - 1)],
                            ($urandom_range(9) == 0) ? $urandom_range(1023)
                                                     : (n > 64 ? 64 : n), n);
                persists++;
            end
            else if (pick < 92) begin
                send_word(1'b1, key_pool[$urandom_range(NKEYS - 1)], $urandom, $urandom,
                          $urandom, ($urandom_range(3) == 0) ? $urandom_range(1023)
                                                             : $urandom_range(70),
                          $urandom);
            end
            else if (pick < 96) begin
                send_word(1'b1, {$urandom, $urandom, $urandom, $urandom,
                                 $urandom, $urandom, $urandom, $urandom},
                          $urandom, $urandom, $urandom, $urandom, $urandom);
            end
            else begin
                // Broken sequence: random length, possibly left open to the next one.
                send_word(1'b0, key_pool[$urandom_range(NKEYS - 1)], $urandom_range(1023),
                          $urandom, $urandom, $urandom, $urandom);
            end
        end
        // Close any sequence left open by a broken one.
        send_word(1'b0, key_pool[0], 1, 8'h77, 1'b1, 0, 1'b0);
        in_valid <= 1'b0;
        gaps_on = 1'b1;

        while (results_owed != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("tb_keyed_descriptor_store_core: PASS");
        else
            $display("tb_keyed_descriptor_store_core: FAIL");
        $finish;
    end

endmodule
